// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks sampled on clk, off while rst_n is low
`ifndef NO_ASSERTIONS
`define AS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AS_ASSERT_NOW(lbl, ante, cons)
`define AS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/arst_pkg.sv
package arst_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_WIDTH = 32;
    localparam int CFG_IDX_W  = 3;

    // reset values in whole units, scaled by the fraction width
    localparam int SLOW_RADIUS_UNITS = 100;
    localparam int STOP_RADIUS_UNITS = 10;
    localparam int MAX_ACCEL_UNITS   = 10;
    localparam int MAX_SPEED_UNITS   = 10;
    localparam int SETTLE_TIME_UNITS = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_RADIUS = 3'd0,
        REG_STOP_RADIUS = 3'd1,
        REG_MAX_ACCEL   = 3'd2,
        REG_MAX_SPEED   = 3'd3,
        REG_SETTLE_TIME = 3'd4
    } cfg_reg_t;

endpackage

// File: hdl/arst_in_if.sv
interface arst_in_if #(
    parameter int W = arst_pkg::WORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] agent_pos_x;
    logic signed [W-1:0] agent_pos_y;
    logic signed [W-1:0] agent_vel_x;
    logic signed [W-1:0] agent_vel_y;
    logic signed [W-1:0] goal_pos_x;
    logic signed [W-1:0] goal_pos_y;

    modport source (
        output valid, agent_pos_x, agent_pos_y, agent_vel_x, agent_vel_y,
               goal_pos_x, goal_pos_y,
        input  ready
    );

    modport sink (
        input  valid, agent_pos_x, agent_pos_y, agent_vel_x, agent_vel_y,
               goal_pos_x, goal_pos_y,
        output ready
    );
endinterface

// File: hdl/arst_out_if.sv
interface arst_out_if #(
    parameter int W = arst_pkg::WORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;
    logic                was_clamped;

    modport source (
        output valid, accel_x, accel_y, was_clamped,
        input  ready
    );

    modport sink (
        input  valid, accel_x, accel_y, was_clamped,
        output ready
    );
endinterface

// File: hdl/arrive_steering.sv
// arrive steering, 2-D, signed fixed point
// agent channel: agent position, velocity and goal position, one item per
//   valid/ready handshake; steer channel: acceleration x/y and was_clamped
// config: cfg_we writes cfg_data into the register at cfg_index; the user
//   writes only while idle, not enforced by the block; an unknown index is ignored
// built from bit-per-stage units: two square roots and seven restoring
//   dividers, each one stage per result bit
// throughput: one item per cycle while the steer side takes results, every stage holds an item at once
// stall: the whole pipeline holds while a result waits on the steer side;
//   agent.ready drops in that cycle and nothing is lost or repeated
// reset: valid bits clear, registers return to slow 100, stop 10,
//   max accel 10, max speed 10, settle time 1
`include "assert_macros.svh"

module arrive_steering #(
    parameter int FRAC_BITS  = arst_pkg::FRAC_BITS,
    parameter int WORD_WIDTH = arst_pkg::WORD_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [arst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_WIDTH-2:0]          cfg_data,
    arst_in_if.sink                        agent,
    arst_out_if.source                     steer
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = W - 1;
    localparam int DW  = W + 1;
    localparam int AW  = W + F;
    localparam int LW  = AW + 1;
    localparam int ALO = AW / 2;
    localparam int AHI = AW - ALO;

    typedef struct packed {
        logic [W-1:0]        adx;
        logic [W-1:0]        ady;
        logic                sx;
        logic                sy;
        logic signed [W-1:0] velx;
        logic signed [W-1:0] vely;
    } kin_t;

    typedef struct packed {
        logic          far;
        logic          band;
        logic [DW-1:0] dmag;
        kin_t          kin;
    } spd_t;

    typedef struct packed {
        logic                dz;
        logic                sx;
        logic signed [W-1:0] velx;
    } velx_t;

    typedef struct packed {
        logic                sy;
        logic signed [W-1:0] vely;
    } vely_t;

    typedef struct packed {
        logic [AW-1:0] axm;
        logic [AW-1:0] aym;
        logic          negx;
        logic          negy;
    } acc_t;

    typedef struct packed {
        logic         clamp;
        logic         neg;
        logic [W-1:0] am;
    } limx_t;

    typedef struct packed {
        logic         neg;
        logic [W-1:0] am;
    } limy_t;

    // configuration registers
    logic [CW-1:0] slow_radius_reg;
    logic [CW-1:0] stop_radius_reg;
    logic [CW-1:0] max_accel_reg;
    logic [CW-1:0] max_speed_reg;
    logic [CW-1:0] settle_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_radius_reg <= CW'(arst_pkg::SLOW_RADIUS_UNITS) << F;
            stop_radius_reg <= CW'(arst_pkg::STOP_RADIUS_UNITS) << F;
            max_accel_reg   <= CW'(arst_pkg::MAX_ACCEL_UNITS) << F;
            max_speed_reg   <= CW'(arst_pkg::MAX_SPEED_UNITS) << F;
            settle_time_reg <= CW'(arst_pkg::SETTLE_TIME_UNITS) << F;
        end
        else if (cfg_we)
        begin
            case (arst_pkg::cfg_reg_t'(cfg_index))
                arst_pkg::REG_SLOW_RADIUS: slow_radius_reg <= cfg_data;
                arst_pkg::REG_STOP_RADIUS: stop_radius_reg <= cfg_data;
                arst_pkg::REG_MAX_ACCEL:   max_accel_reg   <= cfg_data;
                arst_pkg::REG_MAX_SPEED:   max_speed_reg   <= cfg_data;
                arst_pkg::REG_SETTLE_TIME: settle_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless a result waits unread
    logic steer_v_reg;
    logic en;

    assign en          = !steer_v_reg || steer.ready;
    assign agent.ready = en;

    // stage 1: offsets to the goal
    logic signed [W:0] dx, dy;
    kin_t              s1_next;
    logic              s1_v_reg;
    kin_t              s1_reg;

    assign dx = (W+1)'(agent.goal_pos_x) - (W+1)'(agent.agent_pos_x);
    assign dy = (W+1)'(agent.goal_pos_y) - (W+1)'(agent.agent_pos_y);

    always_comb
    begin
        s1_next.adx  = dx[W] ? W'(-dx) : W'(dx);
        s1_next.ady  = dy[W] ? W'(-dy) : W'(dy);
        s1_next.sx   = dx[W];
        s1_next.sy   = dy[W];
        s1_next.velx = agent.agent_vel_x;
        s1_next.vely = agent.agent_vel_y;
    end

    // stage 2: squares, stage 3: sum
    logic            s2_v_reg, s3_v_reg;
    logic [2*W-1:0]  s2_sqx_reg, s2_sqy_reg;
    kin_t            s2_reg, s3_reg;
    logic [2*W:0]    s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= agent.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg     <= s1_next;
            s2_sqx_reg <= s1_reg.adx * s1_reg.adx;
            s2_sqy_reg <= s1_reg.ady * s1_reg.ady;
            s2_reg     <= s1_reg;
            s3_sum_reg <= (2*W+1)'(s2_sqx_reg) + (2*W+1)'(s2_sqy_reg);
            s3_reg     <= s2_reg;
        end
    end

    // distance
    logic          sq1_v;
    logic [DW-1:0] sq1_dist;
    kin_t          sq1_kin;

    arst_sqrt #(.RW(DW), .PW($bits(kin_t))) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid      (s3_v_reg),
        .rad        ((2*DW)'(s3_sum_reg)),
        .tag        (s3_reg),
        .root_valid (sq1_v),
        .root       (sq1_dist),
        .root_tag   (sq1_kin)
    );

    // stage 4: speed band, stage 5: band product
    logic          s4_v_reg, s5_v_reg;
    spd_t          s4_reg, s5_reg;
    logic [CW-1:0] s4_dm_reg, s4_den_reg, s5_den_reg;
    logic [2*CW-1:0] s5_prod_reg;
    logic          far_next, band_next;

    assign far_next  = sq1_dist > DW'(slow_radius_reg);
    assign band_next = !far_next && (sq1_dist > DW'(stop_radius_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= sq1_v;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg.far  <= far_next;
            s4_reg.band <= band_next;
            s4_reg.dmag <= sq1_dist;
            s4_reg.kin  <= sq1_kin;
            s4_dm_reg   <= CW'(sq1_dist - DW'(stop_radius_reg));
            s4_den_reg  <= slow_radius_reg - stop_radius_reg;
            s5_reg      <= s4_reg;
            s5_prod_reg <= s4_dm_reg * max_speed_reg;
            s5_den_reg  <= s4_den_reg;
        end
    end

    logic          dv1_v;
    logic [CW-1:0] dv1_q;
    spd_t          dv1_tag;

    arst_div #(.QW(CW), .DW(CW), .PW($bits(spd_t))) u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s5_v_reg),
        .num       (s5_prod_reg),
        .den       (s5_den_reg),
        .tag       (s5_reg),
        .quo_valid (dv1_v),
        .quo       (dv1_q),
        .quo_tag   (dv1_tag)
    );

    // stage 6: wanted speed, stage 7: direction products
    logic          s6_v_reg, s7_v_reg;
    logic [CW-1:0] s6_speed_reg;
    logic [DW-1:0] s6_dist_reg, s7_dist_reg;
    kin_t          s6_kin_reg;
    logic [W+CW-1:0] s7_px_reg, s7_py_reg;
    velx_t         s7_tx_reg;
    vely_t         s7_ty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= dv1_v;
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_speed_reg   <= dv1_tag.far ? max_speed_reg : (dv1_tag.band ? dv1_q : '0);
            s6_dist_reg    <= dv1_tag.dmag;
            s6_kin_reg     <= dv1_tag.kin;
            s7_px_reg      <= s6_kin_reg.adx * s6_speed_reg;
            s7_py_reg      <= s6_kin_reg.ady * s6_speed_reg;
            s7_dist_reg    <= s6_dist_reg;
            s7_tx_reg.dz   <= s6_dist_reg == '0;
            s7_tx_reg.sx   <= s6_kin_reg.sx;
            s7_tx_reg.velx <= s6_kin_reg.velx;
            s7_ty_reg.sy   <= s6_kin_reg.sy;
            s7_ty_reg.vely <= s6_kin_reg.vely;
        end
    end

    logic          dvx_v, dvy_v;
    logic [CW-1:0] dvx_q, dvy_q;
    velx_t         dvx_tag;
    vely_t         dvy_tag;

    arst_div #(.QW(CW), .DW(DW), .PW($bits(velx_t))) u_velx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s7_v_reg),
        .num       ((CW+DW)'(s7_px_reg)),
        .den       (s7_dist_reg),
        .tag       (s7_tx_reg),
        .quo_valid (dvx_v),
        .quo       (dvx_q),
        .quo_tag   (dvx_tag)
    );

    arst_div #(.QW(CW), .DW(DW), .PW($bits(vely_t))) u_vely (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s7_v_reg),
        .num       ((CW+DW)'(s7_py_reg)),
        .den       (s7_dist_reg),
        .tag       (s7_ty_reg),
        .quo_valid (dvy_v),
        .quo       (dvy_q),
        .quo_tag   (dvy_tag)
    );

    // stage 8: velocity error
    logic signed [W+1:0] vx, vy, ex, ey;
    logic [W+1:0]        vxm_ext, vym_ext;
    logic                s8_v_reg;
    logic [W-1:0]        s8_exm_reg, s8_eym_reg;
    logic                s8_negx_reg, s8_negy_reg;
    logic [CW-1:0]       s8_settle_reg;

    assign vxm_ext = (W+2)'(dvx_q);
    assign vym_ext = (W+2)'(dvy_q);
    assign vx = dvx_tag.dz ? '0 : (dvx_tag.sx ? -vxm_ext : vxm_ext);
    assign vy = dvx_tag.dz ? '0 : (dvy_tag.sy ? -vym_ext : vym_ext);
    assign ex = vx - (W+2)'(dvx_tag.velx);
    assign ey = vy - (W+2)'(dvy_tag.vely);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_v_reg <= 1'b0;
        else if (en)
            s8_v_reg <= dvx_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_exm_reg    <= ex[W+1] ? W'(-ex) : W'(ex);
            s8_eym_reg    <= ey[W+1] ? W'(-ey) : W'(ey);
            s8_negx_reg   <= ex[W+1];
            s8_negy_reg   <= ey[W+1];
            s8_settle_reg <= (settle_time_reg == '0) ? CW'(1) : settle_time_reg;
        end
    end

    logic          dax_v, day_v;
    logic [AW-1:0] dax_q, day_q;
    logic          dax_neg, day_neg;

    arst_div #(.QW(AW), .DW(CW), .PW(1)) u_accx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s8_v_reg),
        .num       ((AW+CW)'({s8_exm_reg, F'(0)})),
        .den       (s8_settle_reg),
        .tag       (s8_negx_reg),
        .quo_valid (dax_v),
        .quo       (dax_q),
        .quo_tag   (dax_neg)
    );

    arst_div #(.QW(AW), .DW(CW), .PW(1)) u_accy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s8_v_reg),
        .num       ((AW+CW)'({s8_eym_reg, F'(0)})),
        .den       (s8_settle_reg),
        .tag       (s8_negy_reg),
        .quo_valid (day_v),
        .quo       (day_q),
        .quo_tag   (day_neg)
    );

    // stage 9: split squares, stage 10: square sums, stage 11: length squared
    logic                s9_v_reg, s10_v_reg, s11_v_reg;
    logic [2*AHI-1:0]    s9_hhx_reg, s9_hhy_reg;
    logic [AHI+ALO-1:0]  s9_hlx_reg, s9_hly_reg;
    logic [2*ALO-1:0]    s9_llx_reg, s9_lly_reg;
    acc_t                s9_reg, s10_reg, s11_reg;
    acc_t                s9_next;
    logic [2*AW-1:0]     sqx_next, sqy_next;
    logic [2*AW-1:0]     s10_sqx_reg, s10_sqy_reg;
    logic [2*AW:0]       s11_sum_reg;

    always_comb
    begin
        s9_next.axm  = dax_q;
        s9_next.aym  = day_q;
        s9_next.negx = dax_neg;
        s9_next.negy = day_neg;
    end

    assign sqx_next = ((2*AW)'(s9_hhx_reg) << (2*ALO)) + ((2*AW)'(s9_hlx_reg) << (ALO+1))
                    + (2*AW)'(s9_llx_reg);
    assign sqy_next = ((2*AW)'(s9_hhy_reg) << (2*ALO)) + ((2*AW)'(s9_hly_reg) << (ALO+1))
                    + (2*AW)'(s9_lly_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s9_v_reg  <= dax_v;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_hhx_reg  <= dax_q[AW-1:ALO] * dax_q[AW-1:ALO];
            s9_hlx_reg  <= dax_q[AW-1:ALO] * dax_q[ALO-1:0];
            s9_llx_reg  <= dax_q[ALO-1:0] * dax_q[ALO-1:0];
            s9_hhy_reg  <= day_q[AW-1:ALO] * day_q[AW-1:ALO];
            s9_hly_reg  <= day_q[AW-1:ALO] * day_q[ALO-1:0];
            s9_lly_reg  <= day_q[ALO-1:0] * day_q[ALO-1:0];
            s9_reg      <= s9_next;
            s10_sqx_reg <= sqx_next;
            s10_sqy_reg <= sqy_next;
            s10_reg     <= s9_reg;
            s11_sum_reg <= (2*AW+1)'(s10_sqx_reg) + (2*AW+1)'(s10_sqy_reg);
            s11_reg     <= s10_reg;
        end
    end

    // acceleration length
    logic          sq2_v;
    logic [LW-1:0] sq2_len;
    acc_t          sq2_acc;

    arst_sqrt #(.RW(LW), .PW($bits(acc_t))) u_len (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid      (s11_v_reg),
        .rad        ((2*LW)'(s11_sum_reg)),
        .tag        (s11_reg),
        .root_valid (sq2_v),
        .root       (sq2_len),
        .root_tag   (sq2_acc)
    );

    // stage 12: clamp test and split products, stage 13: products
    logic                s12_v_reg, s13_v_reg;
    logic [AHI+CW-1:0]   s12_phx_reg, s12_phy_reg;
    logic [ALO+CW-1:0]   s12_plx_reg, s12_ply_reg;
    logic [LW-1:0]       s12_len_reg, s13_len_reg;
    limx_t               s12_tx_reg, s13_tx_reg;
    limy_t               s12_ty_reg, s13_ty_reg;
    logic [AW+CW-1:0]    s13_px_reg, s13_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s12_v_reg <= 1'b0;
            s13_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s12_v_reg <= sq2_v;
            s13_v_reg <= s12_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_phx_reg      <= sq2_acc.axm[AW-1:ALO] * max_accel_reg;
            s12_plx_reg      <= sq2_acc.axm[ALO-1:0] * max_accel_reg;
            s12_phy_reg      <= sq2_acc.aym[AW-1:ALO] * max_accel_reg;
            s12_ply_reg      <= sq2_acc.aym[ALO-1:0] * max_accel_reg;
            s12_len_reg      <= sq2_len;
            s12_tx_reg.clamp <= sq2_len > LW'(max_accel_reg);
            s12_tx_reg.neg   <= sq2_acc.negx;
            s12_tx_reg.am    <= sq2_acc.axm[W-1:0];
            s12_ty_reg.neg   <= sq2_acc.negy;
            s12_ty_reg.am    <= sq2_acc.aym[W-1:0];
            s13_px_reg       <= ((AW+CW)'(s12_phx_reg) << ALO) + (AW+CW)'(s12_plx_reg);
            s13_py_reg       <= ((AW+CW)'(s12_phy_reg) << ALO) + (AW+CW)'(s12_ply_reg);
            s13_len_reg      <= s12_len_reg;
            s13_tx_reg       <= s12_tx_reg;
            s13_ty_reg       <= s12_ty_reg;
        end
    end

    logic          dlx_v, dly_v;
    logic [CW-1:0] dlx_q, dly_q;
    limx_t         dlx_tag;
    limy_t         dly_tag;

    arst_div #(.QW(CW), .DW(LW), .PW($bits(limx_t))) u_limx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s13_v_reg),
        .num       ((CW+LW)'(s13_px_reg)),
        .den       (s13_len_reg),
        .tag       (s13_tx_reg),
        .quo_valid (dlx_v),
        .quo       (dlx_q),
        .quo_tag   (dlx_tag)
    );

    arst_div #(.QW(CW), .DW(LW), .PW($bits(limy_t))) u_limy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (s13_v_reg),
        .num       ((CW+LW)'(s13_py_reg)),
        .den       (s13_len_reg),
        .tag       (s13_ty_reg),
        .quo_valid (dly_v),
        .quo       (dly_q),
        .quo_tag   (dly_tag)
    );

    // output register
    logic [W-1:0] mx, my;
    logic [W-1:0] steer_ax_reg, steer_ay_reg;
    logic         steer_clamp_reg;

    assign mx = dlx_tag.clamp ? W'(dlx_q) : dlx_tag.am;
    assign my = dlx_tag.clamp ? W'(dly_q) : dly_tag.am;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steer_v_reg <= 1'b0;
        else if (en)
            steer_v_reg <= dlx_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            steer_ax_reg    <= dlx_tag.neg ? -mx : mx;
            steer_ay_reg    <= dly_tag.neg ? -my : my;
            steer_clamp_reg <= dlx_tag.clamp;
        end
    end

    assign steer.valid       = steer_v_reg;
    assign steer.accel_x     = steer_ax_reg;
    assign steer.accel_y     = steer_ay_reg;
    assign steer.was_clamped = steer_clamp_reg;

    `AS_ASSERT_NOW(a_dist_bound, sq1_v, sq1_kin.adx <= sq1_dist && sq1_kin.ady <= sq1_dist)
    `AS_ASSERT_NOW(a_len_bound, sq2_v, sq2_acc.axm <= sq2_len && sq2_acc.aym <= sq2_len)
    `AS_ASSERT_NOW(a_vel_lanes, dvx_v || dvy_v, dvx_v && dvy_v)
    `AS_ASSERT_NOW(a_lim_lanes, dlx_v || dly_v || dax_v || day_v,
                   dlx_v == dly_v && dax_v == day_v)

endmodule

// File: hdl/arst_div.sv
module arst_div #(
    parameter int QW = 31,
    parameter int DW = 33,
    parameter int PW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  logic [QW+DW-1:0]  num,
    input  logic [DW-1:0]     den,
    input  logic [PW-1:0]     tag,
    output logic              quo_valid,
    output logic [QW-1:0]     quo,
    output logic [PW-1:0]     quo_tag
);

    // one quotient bit per stage; remainder stays below the divisor
    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] qn_reg  [QW];
    logic [DW-1:0] den_reg [QW];
    logic [PW-1:0] tag_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          v_p;
        logic [DW-1:0] rem_p;
        logic [QW-1:0] qn_p;
        logic [DW-1:0] den_p;
        logic [PW-1:0] tag_p;
        logic [DW:0]   trial;
        logic          fits;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] qn_next;

        if (k == 0)
        begin : g_head
            assign v_p   = valid;
            assign rem_p = num[QW+DW-1:QW];
            assign qn_p  = num[QW-1:0];
            assign den_p = den;
            assign tag_p = tag;
        end
        else
        begin : g_body
            assign v_p   = v_reg[k-1];
            assign rem_p = rem_reg[k-1];
            assign qn_p  = qn_reg[k-1];
            assign den_p = den_reg[k-1];
            assign tag_p = tag_reg[k-1];
        end

        assign trial    = {rem_p, qn_p[QW-1]};
        assign fits     = trial >= {1'b0, den_p};
        assign rem_next = fits ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
        assign qn_next  = QW'({qn_p, fits});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                qn_reg[k]  <= qn_next;
                den_reg[k] <= den_p;
                tag_reg[k] <= tag_p;
            end
        end
    end

    assign quo_valid = v_reg[QW-1];
    assign quo       = qn_reg[QW-1];
    assign quo_tag   = tag_reg[QW-1];

endmodule

// File: hdl/arst_sqrt.sv
module arst_sqrt #(
    parameter int RW = 33,
    parameter int PW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  logic [2*RW-1:0]   rad,
    input  logic [PW-1:0]     tag,
    output logic              root_valid,
    output logic [RW-1:0]     root,
    output logic [PW-1:0]     root_tag
);

    // one root bit per stage, two radicand bits shifted in each time
    logic            v_reg    [RW];
    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] xs_reg   [RW];
    logic [PW-1:0]   tag_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic            v_p;
        logic [RW:0]     rem_p;
        logic [RW-1:0]   root_p;
        logic [2*RW-1:0] xs_p;
        logic [PW-1:0]   tag_p;
        logic [RW+2:0]   acc;
        logic [RW+2:0]   trial;
        logic            fits;
        logic [RW:0]     rem_next;
        logic [RW-1:0]   root_next;

        if (k == 0)
        begin : g_head
            assign v_p    = valid;
            assign rem_p  = '0;
            assign root_p = '0;
            assign xs_p   = rad;
            assign tag_p  = tag;
        end
        else
        begin : g_body
            assign v_p    = v_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign xs_p   = xs_reg[k-1];
            assign tag_p  = tag_reg[k-1];
        end

        assign acc       = {rem_p, xs_p[2*RW-1 -: 2]};
        assign trial     = {1'b0, root_p, 2'b01};
        assign fits      = acc >= trial;
        assign rem_next  = fits ? (RW+1)'(acc - trial) : acc[RW:0];
        assign root_next = RW'({root_p, fits});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                xs_reg[k]   <= xs_p << 2;
                tag_reg[k]  <= tag_p;
            end
        end
    end

    assign root_valid = v_reg[RW-1];
    assign root       = root_reg[RW-1];
    assign root_tag   = tag_reg[RW-1];

endmodule
